/* hdl/assert_macros.svh */
// Assertion macros used by the stack block's top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, skipped while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that an antecedent is followed by a consequent on the next clk edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/mnvps_pkg.sv */
// Types and constants of the note priority stack.
package mnvps_pkg;

	localparam int OP_W   = 3;
	localparam int NOTE_W = 7;
	localparam int IDX_W  = 4;
	localparam int HELD_W = 5;

	typedef logic [NOTE_W-1:0] note_t;

	typedef enum logic [OP_W-1:0] {
		OP_NOTE_ON  = 3'd0,
		OP_NOTE_OFF = 3'd1,
		OP_POP      = 3'd2,
		OP_CLEAR    = 3'd3,
		OP_READ     = 3'd4
	} op_t;

	// Per-cycle commands broadcast to every cell of the chain.
	typedef struct packed {
		logic  push;
		logic  pop;
		logic  remove;
		note_t key;
	} cell_ctrl_t;

endpackage

/* hdl/mnvps_req_if.sv */
// Request channel of the note priority stack.
interface mnvps_req_if;
	logic                        valid;
	logic                        ready;
	logic [mnvps_pkg::OP_W-1:0]  op;
	mnvps_pkg::note_t            note;
	mnvps_pkg::note_t            vel;
	logic [mnvps_pkg::IDX_W-1:0] depth_index;

	modport source (output valid, output op, output note, output vel, output depth_index,
		input ready);
	modport sink (input valid, input op, input note, input vel, input depth_index,
		output ready);
endinterface

/* hdl/mnvps_rsp_if.sv */
// Result channel of the note priority stack.
interface mnvps_rsp_if;
	logic                         valid;
	logic                         ready;
	mnvps_pkg::note_t             out_note;
	mnvps_pkg::note_t             out_vel;
	logic                         found;
	logic [mnvps_pkg::HELD_W-1:0] held_count;

	modport source (output valid, output out_note, output out_vel, output found,
		output held_count, input ready);
	modport sink (input valid, input out_note, input out_vel, input found,
		input held_count, output ready);
endinterface

/* hdl/mnvps_cell.sv */
// One stack cell: holds a note and velocity and trades them with its neighbors.
module mnvps_cell (
	input  logic                  clk,
	input  mnvps_pkg::cell_ctrl_t ctrl,
	input  logic                  occupied,
	input  mnvps_pkg::note_t      up_note,
	input  mnvps_pkg::note_t      up_vel,
	input  mnvps_pkg::note_t      dn_note,
	input  mnvps_pkg::note_t      dn_vel,
	input  logic                  hole_in,
	output mnvps_pkg::note_t      note,
	output mnvps_pkg::note_t      vel,
	output logic                  hole_out
);

	mnvps_pkg::note_t note_q;
	mnvps_pkg::note_t vel_q;
	logic             match;

	// A hole at or above this cell pulls the lower neighbor up by one.
	assign match    = ctrl.remove && occupied && (note_q == ctrl.key);
	assign hole_out = hole_in || match;

	always_ff @(posedge clk) begin
		priority if (ctrl.push) begin
			note_q <= up_note;
			vel_q  <= up_vel;
		end else if (ctrl.pop || (ctrl.remove && hole_out)) begin
			note_q <= dn_note;
			vel_q  <= dn_vel;
		end else begin
			note_q <= note_q;
			vel_q  <= vel_q;
		end
	end

	assign note = note_q;
	assign vel  = vel_q;

endmodule

/* hdl/midi_note_velocity_priority_stack_unit.sv */
// Top level of the last-note priority stack of held notes and velocities.
//
// Requests arrive on req (op, note, vel, depth_index) and each one gives exactly
// one result on rsp (out_note, out_vel, found, held_count), in request order.
// The stack is a row of DEPTH cells; cell 0 holds the most recent note.
// Note on shifts the row down and loads cell 0, pop returns cell 0 and shifts
// the row up, clear only zeroes the count, read picks the cell at depth_index.
// The result of these is in the output register the cycle after the request is
// taken; such requests can be taken every cycle while rsp.ready stays high.
// Note off purges one matching cell per cycle, closing the gap by shifting the
// cells below it up; its result is loaded into the output register in the purge
// cycle that finds no match, with req.ready low meanwhile.
// A full stack drops a note on; pop or read with nothing there returns zeros
// with found low. held_count is the entry count after the request.
// Reset clears the state, the count and the output valid flag; cell contents are
// left as they are, since no cell at or beyond the count is ever read.
// When rsp stalls, the result holds in the output register, and req.ready
// stays low until that result is taken or is taken in the same cycle.
module midi_note_velocity_priority_stack_unit #(
	parameter int DEPTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	mnvps_req_if.sink  req,
	mnvps_rsp_if.source rsp
);

	`include "assert_macros.svh"

	localparam int CW = $clog2(DEPTH + 1);
	localparam int RW = ((CW > mnvps_pkg::IDX_W) ? CW : mnvps_pkg::IDX_W) + 1;

	typedef enum logic {
		ST_IDLE,
		ST_PURGE
	} state_t;

	state_t                        state_q;
	logic [CW-1:0]                 count_q;
	mnvps_pkg::note_t              key_q;
	logic                          out_valid_q;
	mnvps_pkg::note_t              out_note_q;
	mnvps_pkg::note_t              out_vel_q;
	logic                          found_q;
	logic [mnvps_pkg::HELD_W-1:0]  held_q;

	mnvps_pkg::cell_ctrl_t         ctrl;
	mnvps_pkg::note_t              cell_note [DEPTH];
	mnvps_pkg::note_t              cell_vel  [DEPTH];
	logic [DEPTH:0]                hole;

	logic                          accept;
	logic                          full;
	logic                          empty;
	logic                          load_res;
	logic                          rd_hit;
	mnvps_pkg::note_t              rd_note;
	mnvps_pkg::note_t              rd_vel;
	logic [CW-1:0]                 count_d;
	logic [CW+mnvps_pkg::HELD_W-1:0] count_ext;
	logic [CW+mnvps_pkg::HELD_W-1:0] count_d_ext;
	mnvps_pkg::note_t              res_note;
	mnvps_pkg::note_t              res_vel;
	logic                          res_found;

	assign req.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);

	// Load the output register for any request but note off, or when a purge ends.
	assign load_res = (accept && (req.op != mnvps_pkg::OP_NOTE_OFF))
		|| ((state_q == ST_PURGE) && !hole[DEPTH]);

	// Broadcast commands; note off only purges from the cycle after it is taken.
	always_comb begin
		ctrl.push   = accept && (req.op == mnvps_pkg::OP_NOTE_ON) && !full;
		ctrl.pop    = accept && (req.op == mnvps_pkg::OP_POP) && !empty;
		ctrl.remove = (state_q == ST_PURGE);
		ctrl.key    = key_q;
	end

	assign hole[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		mnvps_pkg::note_t up_note;
		mnvps_pkg::note_t up_vel;
		mnvps_pkg::note_t dn_note;
		mnvps_pkg::note_t dn_vel;

		if (i == 0) begin : g_top
			assign up_note = req.note;
			assign up_vel  = req.vel;
		end else begin : g_mid
			assign up_note = cell_note[i-1];
			assign up_vel  = cell_vel[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign dn_note = cell_note[i];
			assign dn_vel  = cell_vel[i];
		end else begin : g_inner
			assign dn_note = cell_note[i+1];
			assign dn_vel  = cell_vel[i+1];
		end

		mnvps_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.occupied (CW'(i) < count_q),
			.up_note  (up_note),
			.up_vel   (up_vel),
			.dn_note  (dn_note),
			.dn_vel   (dn_vel),
			.hole_in  (hole[i]),
			.note     (cell_note[i]),
			.vel      (cell_vel[i]),
			.hole_out (hole[i+1])
		);
	end

	// Read port: AND-OR select of the cell at depth_index.
	assign rd_hit = (RW'(req.depth_index) < RW'(count_q));

	always_comb begin
		rd_note = '0;
		rd_vel  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (RW'(req.depth_index) == RW'(i)) begin
				rd_note = rd_note | cell_note[i];
				rd_vel  = rd_vel | cell_vel[i];
			end
		end
	end

	// Result fields and next count of a request taken in the idle state.
	always_comb begin
		res_note  = '0;
		res_vel   = '0;
		res_found = 1'b0;
		count_d   = count_q;
		unique case (req.op)
			mnvps_pkg::OP_NOTE_ON: begin
				if (!full) count_d = count_q + CW'(1);
			end
			mnvps_pkg::OP_POP: begin
				if (!empty) begin
					count_d   = count_q - CW'(1);
					res_note  = cell_note[0];
					res_vel   = cell_vel[0];
					res_found = 1'b1;
				end
			end
			mnvps_pkg::OP_CLEAR: begin
				count_d = '0;
			end
			mnvps_pkg::OP_READ: begin
				if (rd_hit) begin
					res_note  = rd_note;
					res_vel   = rd_vel;
					res_found = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign count_ext   = {{mnvps_pkg::HELD_W{1'b0}}, count_q};
	assign count_d_ext = {{mnvps_pkg::HELD_W{1'b0}}, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_res) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.op == mnvps_pkg::OP_NOTE_OFF) begin
							key_q   <= req.note;
							state_q <= ST_PURGE;
						end else begin
							count_q     <= count_d;
							out_note_q  <= res_note;
							out_vel_q   <= res_vel;
							found_q     <= res_found;
							held_q      <= count_d_ext[mnvps_pkg::HELD_W-1:0];
						end
					end
				end
				ST_PURGE: begin
					if (hole[DEPTH]) begin
						// Drop one matching cell; keep purging.
						count_q <= count_q - CW'(1);
					end else begin
						out_note_q  <= '0;
						out_vel_q   <= '0;
						found_q     <= 1'b0;
						held_q      <= count_ext[mnvps_pkg::HELD_W-1:0];
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.out_note   = out_note_q;
	assign rsp.out_vel    = out_vel_q;
	assign rsp.found      = found_q;
	assign rsp.held_count = held_q;

	`ASSERT_CLK(a_count_bound, count_q <= CW'(DEPTH), "entry count exceeds depth")
	`ASSERT_NEXT(a_push_grows, ctrl.push, count_q == $past(count_q) + CW'(1),
		"note on with room did not grow the count")
	`ASSERT_NEXT(a_purge_shrinks, state_q == ST_PURGE, count_q <= $past(count_q),
		"count grew during a note off purge")
	`ASSERT_NEXT(a_result_loaded, accept && (req.op != mnvps_pkg::OP_NOTE_OFF), out_valid_q,
		"one-cycle request left no result")

endmodule
